/* rtl/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg: shared definitions for the URL percent decoder
// Character codes, escape phase codes, the result item type and the hex
// digit helpers used by the decoder datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    // Character codes the decoder looks for or produces.
    localparam logic [7:0] C_PERCENT = 8'h25;
    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_ZERO    = 8'h30;
    localparam logic [7:0] C_NINE    = 8'h39;
    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_F = 8'h66;
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_UPPER_F = 8'h46;
    localparam logic [7:0] C_CASE_BIT = 8'h20;
    localparam logic [7:0] C_TEN     = 8'd10;

    // Escape phase codes: nothing held, '%' held, '%' and one hex digit held.
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_HEX  = 2'd2;

    // Result queue geometry.
    localparam int unsigned MAX_RES   = 3;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_AW      = 2;
    localparam int unsigned Q_CW      = 3;

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       truncated;
    } t_result;

    // True for 0-9, a-f and A-F.
    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= C_ZERO) && (c <= C_NINE)) ||
               ((c >= C_LOWER_A) && (c <= C_LOWER_F)) ||
               ((c >= C_UPPER_A) && (c <= C_UPPER_F));
    endfunction

    // Nibble value of a hex digit; letters of either case fold to lower case.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if ((c >= C_ZERO) && (c <= C_NINE)) begin
            t = c - C_ZERO;
        end else begin
            t = (c | C_CASE_BIT) - C_LOWER_A + C_TEN;
        end
        return t[3:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/url_percent_decoder.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes one encoded character per item into up to three decoded bytes,
// caps the decoded bytes of each string and marks the end of each string.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  -----------------------------------------
//  input     i_valid / o_ready    i_in_byte, i_in_last
//  output    o_valid / i_ready    o_out_byte, o_byte_valid,
//                                 o_end_of_string, o_truncated
//  config    i_cfg_we             i_cfg_wdata (max_output)
//
//  An input item is decoded in the cycle it is accepted and its zero to three
//  results enter a four-entry result queue; results leave one per cycle while
//  i_ready is high. The input takes an item whenever at most one result is
//  queued, so items that give one result each flow at one per clock even with
//  a result waiting if i_ready stays high. An item giving two or three results
//  holds the input while the queue drains. Reset is synchronous and active low;
//  it empties the queue, clears the escape state and sets max_output to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_end_of_string,
    output logic             o_truncated,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    // Configuration and decoder state.
    logic [15:0] r_max_output;
    logic [1:0]  r_phase,   n_phase;
    logic [7:0]  r_held,    n_held;
    logic [15:0] r_count,   n_count;
    logic        r_dropped, n_dropped;

    // Result queue.
    upd_pkg::t_result r_queue [upd_pkg::Q_DEPTH];
    logic [upd_pkg::Q_AW-1:0] r_rd;
    logic [upd_pkg::Q_CW-1:0] r_qcnt;

    // Decode outputs for the current item.
    logic [7:0]       cand [upd_pkg::MAX_RES];
    logic [1:0]       cand_n;
    logic [1:0]       kept_n;
    logic [1:0]       res_n;
    logic             trunc_now;
    upd_pkg::t_result res [upd_pkg::MAX_RES];

    logic accept_in;
    logic pop_out;
    logic [upd_pkg::Q_AW-1:0] wr_base;

    assign o_ready   = (r_qcnt <= upd_pkg::Q_CW'(1));
    assign accept_in = i_valid && o_ready;
    assign o_valid   = (r_qcnt != '0);
    assign pop_out   = o_valid && i_ready;
    assign wr_base   = r_rd + r_qcnt[upd_pkg::Q_AW-1:0];

    assign o_out_byte      = r_queue[r_rd].out_byte;
    assign o_byte_valid    = r_queue[r_rd].byte_valid;
    assign o_end_of_string = r_queue[r_rd].end_of_string;
    assign o_truncated     = r_queue[r_rd].truncated;

    // Decode: list the candidate bytes this item releases, apply the cap and
    // work out the next escape state.
    always_comb begin
        logic       b_hex;
        logic       fresh_emit;
        logic [7:0] fresh_byte;
        logic [1:0] fresh_phase;
        logic [1:0] mid_phase;
        logic [7:0] mid_held;
        logic [16:0] avail;

        b_hex       = upd_pkg::is_hex(i_in_byte);
        fresh_emit  = (i_in_byte != upd_pkg::C_PERCENT);
        fresh_byte  = (i_in_byte == upd_pkg::C_PLUS) ? upd_pkg::C_SPACE : i_in_byte;
        fresh_phase = fresh_emit ? upd_pkg::PH_NONE : upd_pkg::PH_PCT;
        mid_phase   = upd_pkg::PH_NONE;
        mid_held    = '0;
        cand_n      = '0;
        for (int j = 0; j < upd_pkg::MAX_RES; j++) begin
            cand[j] = '0;
        end

        // Bytes released by the escape that was pending.
        unique case (r_phase)
            upd_pkg::PH_PCT: begin
                if (b_hex) begin
                    mid_phase = upd_pkg::PH_HEX;
                    mid_held  = i_in_byte;
                end else begin
                    cand[cand_n] = upd_pkg::C_PERCENT;
                    cand_n       = cand_n + 2'd1;
                    if (fresh_emit) begin
                        cand[cand_n] = fresh_byte;
                        cand_n       = cand_n + 2'd1;
                    end
                    mid_phase = fresh_phase;
                end
            end
            upd_pkg::PH_HEX: begin
                if (b_hex) begin
                    cand[cand_n] = {upd_pkg::hex_val(r_held), upd_pkg::hex_val(i_in_byte)};
                    cand_n       = cand_n + 2'd1;
                end else begin
                    cand[cand_n] = upd_pkg::C_PERCENT;
                    cand_n       = cand_n + 2'd1;
                    cand[cand_n] = r_held;
                    cand_n       = cand_n + 2'd1;
                    if (fresh_emit) begin
                        cand[cand_n] = fresh_byte;
                        cand_n       = cand_n + 2'd1;
                    end
                    mid_phase = fresh_phase;
                end
            end
            default: begin
                if (fresh_emit) begin
                    cand[cand_n] = fresh_byte;
                    cand_n       = cand_n + 2'd1;
                end
                mid_phase = fresh_phase;
            end
        endcase

        // At the end of a string a pending escape passes through literally.
        if (i_in_last) begin
            if (mid_phase == upd_pkg::PH_PCT) begin
                cand[cand_n] = upd_pkg::C_PERCENT;
                cand_n       = cand_n + 2'd1;
            end else if (mid_phase == upd_pkg::PH_HEX) begin
                cand[cand_n] = upd_pkg::C_PERCENT;
                cand_n       = cand_n + 2'd1;
                cand[cand_n] = mid_held;
                cand_n       = cand_n + 2'd1;
            end
        end

        // Cap: only the first bytes that fit under max_output are kept.
        avail = (r_max_output > r_count) ?
                ({1'b0, r_max_output} - {1'b0, r_count}) : 17'd0;
        kept_n    = (avail >= 17'(cand_n)) ? cand_n : avail[1:0];
        trunc_now = r_dropped || (kept_n != cand_n);
        res_n     = (i_in_last && (kept_n == 2'd0)) ? 2'd1 : kept_n;

        // Result items, with the end marker on the last one of the string.
        for (int j = 0; j < upd_pkg::MAX_RES; j++) begin
            res[j].out_byte      = (2'(j) < kept_n) ? cand[j] : 8'd0;
            res[j].byte_valid    = (2'(j) < kept_n);
            res[j].end_of_string = i_in_last && (2'(j) == (res_n - 2'd1));
            res[j].truncated     = trunc_now;
        end

        // Next state; the end of a string returns everything to its reset value.
        if (i_in_last) begin
            n_phase   = upd_pkg::PH_NONE;
            n_held    = '0;
            n_count   = '0;
            n_dropped = 1'b0;
        end else begin
            n_phase   = mid_phase;
            n_held    = mid_held;
            n_count   = r_count + 16'(kept_n);
            n_dropped = trunc_now;
        end
    end

    // Configuration register and decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_output <= 16'hFFFF;
            r_phase      <= upd_pkg::PH_NONE;
            r_held       <= '0;
            r_count      <= '0;
            r_dropped    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_output <= i_cfg_wdata;
            end
            if (accept_in) begin
                r_phase   <= n_phase;
                r_held    <= n_held;
                r_count   <= n_count;
                r_dropped <= n_dropped;
            end
        end
    end

    // Result queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= '0;
            r_qcnt <= '0;
        end else begin
            if (pop_out) begin
                r_rd <= r_rd + upd_pkg::Q_AW'(1);
            end
            r_qcnt <= r_qcnt + (accept_in ? upd_pkg::Q_CW'(res_n) : '0)
                             - (pop_out ? upd_pkg::Q_CW'(1) : '0);
        end
    end

    // Result queue storage: the item's results go in behind those waiting.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            for (int j = 0; j < upd_pkg::MAX_RES; j++) begin
                if (2'(j) < res_n) begin
                    r_queue[wr_base + upd_pkg::Q_AW'(j)] <= res[j];
                end
            end
        end
    end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for url_percent_decoder
// Sends encoded strings, directed and random, through the input
// channel with random gaps and output stalls. A decoder model in the bench
// predicts every result item, and each item on the output channel is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 36;

    // Clock, reset and block ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_end_of_string;
    logic        o_truncated;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    // Decoder model state and the results it expects.
    logic [15:0] max_bytes    = 16'hFFFF;
    logic [1:0]  esc_state    = upd_pkg::PH_NONE;
    logic [7:0]  held_digit   = 8'h00;
    logic [15:0] bytes_out    = 16'h0000;
    logic        bytes_lost   = 1'b0;
    logic [7:0]  staged [0:2];
    int          staged_cnt;
    upd_pkg::t_result decoded_q [$];
    upd_pkg::t_result want;

    // Stimulus controls shared with the receiver.
    bit          send_calm    = 1'b0;
    bit          recv_calm    = 1'b0;
    int          hold_request = 0;
    int          hold_left    = 0;

    // Run statistics.
    int          mismatches   = 0;
    int          items_taken  = 0;
    int          results_seen = 0;
    int          strings_done = 0;
    int          cap_writes   = 0;
    int          cycle_count  = 0;

    url_percent_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_truncated     (o_truncated),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function automatic bit is_hex_char(input logic [7:0] c);
        return c inside {[upd_pkg::C_ZERO:upd_pkg::C_NINE],
                         [upd_pkg::C_UPPER_A:upd_pkg::C_UPPER_F],
                         [upd_pkg::C_LOWER_A:upd_pkg::C_LOWER_F]};
    endfunction

    // Digits carry their value in the low nibble; letters of both cases
    // carry it as the low nibble plus nine.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c <= upd_pkg::C_NINE) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    // Stage one decoded byte unless the per-string cap is used up.
    function automatic void put_byte(input logic [7:0] v);
        if (bytes_out < max_bytes && staged_cnt < upd_pkg::MAX_RES) begin
            staged[staged_cnt] = v;
            staged_cnt++;
            bytes_out++;
        end else begin
            bytes_lost = 1'b1;
        end
    endfunction

    // Decode a character with no escape pending.
    function automatic void start_fresh(input logic [7:0] c);
        esc_state = upd_pkg::PH_NONE;
        if (c == upd_pkg::C_PERCENT) begin
            esc_state = upd_pkg::PH_PCT;
        end else if (c == upd_pkg::C_PLUS) begin
            put_byte(upd_pkg::C_SPACE);
        end else begin
            put_byte(c);
        end
    endfunction

    // Work out the results of one accepted character and queue them.
    function automatic void decode_char(input logic [7:0] c, input logic last);
        upd_pkg::t_result r;
        staged_cnt = 0;
        case (esc_state)
            upd_pkg::PH_PCT: begin
                if (is_hex_char(c)) begin
                    held_digit = c;
                    esc_state  = upd_pkg::PH_HEX;
                end else begin
                    put_byte(upd_pkg::C_PERCENT);
                    start_fresh(c);
                end
            end
            upd_pkg::PH_HEX: begin
                if (is_hex_char(c)) begin
                    put_byte({nibble_of(held_digit), nibble_of(c)});
                    esc_state  = upd_pkg::PH_NONE;
                    held_digit = 8'h00;
                end else begin
                    put_byte(upd_pkg::C_PERCENT);
                    put_byte(held_digit);
                    held_digit = 8'h00;
                    start_fresh(c);
                end
            end
            default: begin
                start_fresh(c);
            end
        endcase

        // A pending escape at the end of the string goes out literally.
        if (last) begin
            if (esc_state == upd_pkg::PH_PCT) begin
                put_byte(upd_pkg::C_PERCENT);
            end else if (esc_state == upd_pkg::PH_HEX) begin
                put_byte(upd_pkg::C_PERCENT);
                put_byte(held_digit);
            end
        end

        for (int k = 0; k < staged_cnt; k++) begin
            r.out_byte      = staged[k];
            r.byte_valid    = 1'b1;
            r.end_of_string = last && (k == staged_cnt - 1);
            r.truncated     = bytes_lost;
            decoded_q.push_back(r);
        end

        // End of string: a bare end marker if nothing else carries it.
        if (last) begin
            if (staged_cnt == 0) begin
                r.out_byte      = 8'h00;
                r.byte_valid    = 1'b0;
                r.end_of_string = 1'b1;
                r.truncated     = bytes_lost;
                decoded_q.push_back(r);
            end
            esc_state  = upd_pkg::PH_NONE;
            held_digit = 8'h00;
            bytes_out  = 16'h0000;
            bytes_lost = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted item and checks each result.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("mismatch on result %0d: %s is %0h, expected %0h",
                 results_seen, what, got, wanted);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                max_bytes = i_cfg_wdata;
            end
            if (i_valid && o_ready) begin
                decode_char(i_in_byte, i_in_last);
                items_taken++;
                if (i_in_last) begin
                    strings_done++;
                end
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result, byte", o_out_byte, 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        report_mismatch("out_byte", o_out_byte, want.out_byte);
                    end
                    if (o_byte_valid !== want.byte_valid) begin
                        report_mismatch("byte_valid", o_byte_valid, want.byte_valid);
                    end
                    if (o_end_of_string !== want.end_of_string) begin
                        report_mismatch("end_of_string", o_end_of_string,
                                        want.end_of_string);
                    end
                    if (o_truncated !== want.truncated) begin
                        report_mismatch("truncated", o_truncated, want.truncated);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, calm stretches and long hold-offs.
    // ------------------------------------------------------------------

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (recv_calm) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks. Each is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Offer one character and wait until the block takes it. Each cycle
    // before the offer idles with the same chance as the receiver.
    task automatic send_char(input logic [7:0] c, input logic last);
        while (!send_calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= c;
        i_in_last <= last;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        @(negedge i_clk);
    endtask

    // Send a text, marking its final character as the end of the string when close is set.
    task automatic send_text(input string s, input bit close);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], close && (k == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    // Let the block drain, then write the output cap.
    task automatic set_cap(input logic [15:0] v);
        i_valid <= 1'b0;
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Escapes in both cases, plus signs, broken escapes and escapes left
    // pending at the end of a string, with the bytes 01 and FF as literals.
    task automatic test_escapes();
        send_char(8'h01, 1'b0);
        send_text("%41", 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("%6a%fF", 1'b1);
        send_text("%4%zz", 1'b1);
        send_text("%a+%7", 1'b1);
    endtask

    // A cap of zero drops everything; a small cap drops the tail.
    task automatic test_output_cap();
        set_cap(16'h0000);
        send_text("ab", 1'b1);
        set_cap(16'd2);
        send_text("%41b%", 1'b1);
        set_cap(16'hFFFF);
    endtask

    // Random strings mixing well-formed escapes with noise, under changing caps.
    task automatic test_random_strings(input int budget);
        logic [7:0] chars [$];
        int         sent;
        int         len;
        int         pick;
        int         count;
        sent  = 0;
        count = 0;
        while (sent < budget) begin
            if (count % 6 == 0) begin
                case ($urandom_range(5))
                    0: set_cap(16'h0000);
                    1: set_cap(16'd1);
                    2: set_cap(16'($urandom_range(2, 6)));
                    3: set_cap(16'($urandom_range(0, 65535)));
                    default: set_cap(16'hFFFF);
                endcase
            end
            count++;
            len = $urandom_range(1, 12);
            chars.delete();
            while (chars.size() < len) begin
                pick = $urandom_range(99);
                if (pick < 25) begin
                    chars.push_back(upd_pkg::C_PERCENT);
                    chars.push_back(rand_hex());
                    chars.push_back(rand_hex());
                end else if (pick < 35) begin
                    chars.push_back(upd_pkg::C_PLUS);
                end else if (pick < 45) begin
                    chars.push_back(upd_pkg::C_PERCENT);
                    chars.push_back(rand_hex());
                    chars.push_back(8'($urandom_range(1, 255)));
                end else if (pick < 50) begin
                    chars.push_back(upd_pkg::C_PERCENT);
                end else if (pick < 80) begin
                    chars.push_back(8'($urandom_range(8'h21, 8'h7E)));
                end else begin
                    chars.push_back(8'($urandom_range(1, 255)));
                end
            end
            foreach (chars[k]) begin
                send_char(chars[k], k == chars.size() - 1);
            end
            sent += chars.size();
        end
        set_cap(16'hFFFF);
    endtask

    // The receiver holds off while escapes that give three results each
    // keep coming, so the result queue fills and the input stalls.
    task automatic test_backpressure();
        send_calm    = 1'b1;
        hold_request = 120;
        for (int k = 0; k < 6; k++) begin
            send_char(upd_pkg::C_PERCENT, 1'b0);
            send_char(rand_hex(), 1'b0);
            send_char(upd_pkg::C_PLUS, k == 5);
        end
        send_calm = 1'b0;
    endtask

    // Plain characters at full rate with neither side idling.
    task automatic test_full_rate();
        send_calm = 1'b1;
        recv_calm = 1'b1;
        for (int k = 0; k < 30; k++) begin
            send_char(8'($urandom_range(8'h21, 8'h7E)), k == 29);
        end
        send_calm = 1'b0;
        recv_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int waited;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in_byte   = 8'h00;
        i_in_last   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 16'h0000;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_escapes();
        test_output_cap();
        test_random_strings(200);
        test_backpressure();
        test_full_rate();

        // Drain what is still in flight, then allow a few more cycles.
        i_valid <= 1'b0;
        waited = 0;
        while (decoded_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (decoded_q.size() != 0) begin
            report_mismatch("results never delivered, count", 0, decoded_q.size());
        end
        repeat (10) @(posedge i_clk);

        $display("Covered %0d items in %0d strings under %0d cap settings,",
                 items_taken, strings_done, cap_writes);
        $display("with %0d results checked and %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/upd_pkg.sv
rtl/url_percent_decoder.sv
verif/testbench.sv
